// ===== hdl/kf3_pkg.sv =====
// kf3_pkg: types, constants and helpers of the three-state kalman filter
// depends on nothing; used by kalman_filter_3state_scalar_meas
`timescale 1ns / 1ps

package kf3_pkg;

  localparam int STATE_COUNT = 3;
  localparam int DIV_STEPS   = 48;

  // configuration register indexes
  localparam logic [3:0] CFG_PHI_0   = 4'd0;
  localparam logic [3:0] CFG_PHI_1   = 4'd1;
  localparam logic [3:0] CFG_PHI_2   = 4'd2;
  localparam logic [3:0] CFG_GAMMA_0 = 4'd3;
  localparam logic [3:0] CFG_GAMMA_1 = 4'd4;
  localparam logic [3:0] CFG_GAMMA_2 = 4'd5;
  localparam logic [3:0] CFG_OBS     = 4'd6;
  localparam logic [3:0] CFG_NOISE   = 4'd7;

  localparam logic [47:0] PHI_0_RST   = 48'd352294679347;
  localparam logic [47:0] PHI_1_RST   = 48'd7035908063232;
  localparam logic [47:0] PHI_2_RST   = 48'd63333587746816;
  localparam logic [47:0] GAMMA_0_RST = 48'd176147349504;
  localparam logic [47:0] GAMMA_1_RST = 48'd3518651957248;
  localparam logic [47:0] GAMMA_2_RST = 48'd70368744177664;
  localparam logic [47:0] OBS_RST     = 48'd63334607831040;
  localparam logic [63:0] NOISE_RST   = 64'd461063047115833754;

  // 100.0 in q16.16
  localparam logic signed [31:0] P_DIAG_RST = 32'sd6553600;
  // ceil(2^37 / 625): floor(b / 625) = (b * CONV_RECIP) >> 37 for b below 2^27
  localparam logic signed [31:0] CONV_RECIP = 32'sd219902326;
  localparam logic signed [32:0] RAW_ROUND = 33'sd5000;

  typedef struct packed {
    logic signed [15:0] measurement;
    logic signed [15:0] drive_0;
    logic signed [15:0] drive_1;
    logic signed [15:0] drive_2;
  } kf_in_t;

  typedef struct packed {
    logic signed [31:0] estimate_0;
    logic signed [31:0] estimate_1;
    logic signed [31:0] estimate_2;
    logic               overflow;
  } kf_out_t;

  typedef struct packed {
    logic               ov;
    logic signed [31:0] val;
  } kf_sat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CONV, ST_XP, ST_PT, ST_PM, ST_PH, ST_HP, ST_S, ST_HX,
    ST_ETA, ST_GAIN, ST_XU, ST_PU, ST_DONE
  } kf_state_e;

  typedef enum logic [1:0] {
    SUB_ISSUE, SUB_WAIT, SUB_FIN
  } kf_sub_e;

  // signed q2.14 lane of a packed coefficient row
  function automatic logic signed [31:0] lane_s(input logic [47:0] r, input logic [1:0] k);
    logic [15:0] v;
    v = r[16*k +: 16];
    return {{16{v[15]}}, v};
  endfunction

  function automatic kf_sat_t sat32(input logic signed [65:0] v);
    kf_sat_t res;
    if (v > 66'sd2147483647) begin
      res.ov  = 1'b1;
      res.val = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      res.ov  = 1'b1;
      res.val = 32'sh80000000;
    end else begin
      res.ov  = 1'b0;
      res.val = v[31:0];
    end
    return res;
  endfunction

endpackage

// ===== hdl/kalman_filter_3state_scalar_meas.sv =====
// kalman_filter_3state_scalar_meas: three-state kalman filter, scalar measurement
// one shared 32x32 multiply-accumulate unit and one radix-2 divider under a sequencer
// depends on kf3_pkg
`timescale 1ns / 1ps

// channel | direction | handshake                 | word
// in      | input     | in_valid_i / in_ready_o   | kf_in_t: measurement, three drives
// out     | output    | out_valid_o / out_ready_i | kf_out_t: three estimates, overflow
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// per word, 112 multiply terms issue one per cycle on the shared multiplier while a value
// is being issued, and each of the 45 values then waits and finishes; three gains run on
// the 48-step divider, and the innovation, the output handoff and idle take a state each
// in_ready_o is high only while idle; the result sits in an output register, so the
// next word is taken while it waits; a new result waits for that register to empty
// rst_ni clears state and covariance to their reset values and loads register defaults

module kalman_filter_3state_scalar_meas (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  kf3_pkg::kf_in_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output kf3_pkg::kf_out_t out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [3:0]      cfg_index_i,
  input  logic [63:0]     cfg_data_i
);
  import kf3_pkg::*;

  // configuration registers
  logic [47:0] phi_q [STATE_COUNT];
  logic [47:0] gam_q [STATE_COUNT];
  logic [47:0] obs_q;
  logic [63:0] noise_q;

  // filter state
  logic signed [31:0] x_q [STATE_COUNT];
  logic signed [31:0] p_q [STATE_COUNT][STATE_COUNT];

  // per-word scratch values
  kf_in_t             raw_q;
  logic signed [31:0] y_q;
  logic signed [31:0] u_q   [STATE_COUNT];
  logic signed [31:0] xm_q  [STATE_COUNT];
  logic signed [31:0] tmp_q [STATE_COUNT][STATE_COUNT];
  logic signed [31:0] pm_q  [STATE_COUNT][STATE_COUNT];
  logic signed [31:0] ph_q  [STATE_COUNT];
  logic signed [31:0] hp_q  [STATE_COUNT];
  logic signed [31:0] k_q   [STATE_COUNT];
  logic signed [31:0] s_q, hx_q, eta_q;
  logic               ovf_q;

  // sequencer
  kf_state_e state_q, state_d;
  kf_sub_e   sub_q, sub_d;
  logic [1:0] i_q, i_d, j_q, j_d;
  logic [2:0] m_q, m_d;

  // multiply-accumulate unit
  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod_q, acc_q;
  logic               pvld_q;

  // divider
  logic [47:0] dnum_q;
  logic [31:0] drem_q, dden_q;
  logic        dneg_q;
  logic [5:0]  dcnt_q;

  // output register
  kf_out_t out_q;
  logic    out_valid_q;

  logic is_mac, is_div, two_idx, last_job, issue_mac, fin, sh16, neg;
  logic [2:0] nterms;
  logic [1:0] m2;
  kf_state_e next_job;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    is_mac = 1'b0;
    is_div = 1'b0;
    two_idx = 1'b0;
    nterms = 3'd3;
    next_job = ST_DONE;
    unique case (state_q)
      ST_CONV: begin is_mac = 1'b1; nterms = 3'd1; next_job = ST_XP; end
      ST_XP:   begin is_mac = 1'b1; nterms = 3'd6; next_job = ST_PT; end
      ST_PT:   begin is_mac = 1'b1; two_idx = 1'b1; next_job = ST_PM; end
      ST_PM:   begin is_mac = 1'b1; two_idx = 1'b1; next_job = ST_PH; end
      ST_PH:   begin is_mac = 1'b1; next_job = ST_HP; end
      ST_HP:   begin is_mac = 1'b1; next_job = ST_S; end
      ST_S:    begin is_mac = 1'b1; next_job = ST_HX; end
      ST_HX:   begin is_mac = 1'b1; next_job = ST_ETA; end
      ST_GAIN: begin is_div = 1'b1; next_job = ST_XU; end
      ST_XU:   begin is_mac = 1'b1; nterms = 3'd1; next_job = ST_PU; end
      ST_PU:   begin is_mac = 1'b1; nterms = 3'd1; two_idx = 1'b1; next_job = ST_DONE; end
      default: ;
    endcase
  end

  // single-valued jobs, the four input conversions, one row of values, or a full 3x3 matrix
  always_comb begin
    if (state_q == ST_S || state_q == ST_HX) begin
      last_job = 1'b1;
    end else if (state_q == ST_CONV) begin
      last_job = (i_q == 2'd3);
    end else if (two_idx) begin
      last_job = (i_q == 2'd2) && (j_q == 2'd2);
    end else begin
      last_job = (i_q == 2'd2);
    end
  end

  assign issue_mac = is_mac && (sub_q == SUB_ISSUE);
  assign fin       = (is_mac || is_div) && (sub_q == SUB_FIN);

  // next state
  always_comb begin
    state_d = state_q;
    sub_d   = sub_q;
    i_d     = i_q;
    j_d     = j_q;
    m_d     = m_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CONV;
          sub_d   = SUB_ISSUE;
          i_d     = 2'd0;
          j_d     = 2'd0;
          m_d     = 3'd0;
        end
      end
      ST_ETA: state_d = ST_GAIN;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: begin
        unique case (sub_q)
          SUB_ISSUE: begin
            if (is_div) begin
              sub_d = SUB_WAIT;
            end else begin
              m_d = m_q + 3'd1;
              if (m_q == nterms - 3'd1) sub_d = SUB_WAIT;
            end
          end
          SUB_WAIT: begin
            if (!is_div || dcnt_q == 6'(DIV_STEPS - 1)) sub_d = SUB_FIN;
          end
          SUB_FIN: begin
            m_d   = 3'd0;
            sub_d = SUB_ISSUE;
            if (last_job) begin
              state_d = next_job;
              i_d     = 2'd0;
              j_d     = 2'd0;
            end else if (two_idx && j_q != 2'd2) begin
              j_d = j_q + 2'd1;
            end else begin
              i_d = i_q + 2'd1;
              j_d = 2'd0;
            end
          end
          default: sub_d = SUB_ISSUE;
        endcase
      end
    endcase
  end

  // input conversion: floor((raw*65536 + 5000) / 10000) as floor((n >> 4) / 625)
  // by reciprocal multiply; a negative numerator is divided as its complement
  logic signed [15:0] raw_sel;
  logic signed [32:0] conv_n;
  logic [32:0]        conv_a;
  logic [31:0]        conv_mag, conv_val;

  always_comb begin
    unique case (i_q)
      2'd0:    raw_sel = raw_q.measurement;
      2'd1:    raw_sel = raw_q.drive_0;
      2'd2:    raw_sel = raw_q.drive_1;
      default: raw_sel = raw_q.drive_2;
    endcase
  end

  assign conv_n   = {raw_sel[15], raw_sel, 16'h0000} + RAW_ROUND;
  assign conv_a   = conv_n[32] ? ~conv_n : conv_n;
  assign conv_mag = 32'(acc_q[63:37]);
  assign conv_val = conv_n[32] ? ~conv_mag : conv_mag;

  // operand select for the shared multiplier
  assign m2 = (m_q >= 3'd3) ? 2'(m_q - 3'd3) : m_q[1:0];

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_q)
      ST_CONV: begin op_a = {3'b000, conv_a[32:4]}; op_b = CONV_RECIP; end
      ST_XP: begin
        if (m_q < 3'd3) begin
          op_a = x_q[m2];
          op_b = lane_s(phi_q[i_q], m2);
        end else begin
          op_a = u_q[m2];
          op_b = lane_s(gam_q[i_q], m2);
        end
      end
      ST_PT: begin op_a = p_q[m2][j_q];   op_b = lane_s(phi_q[i_q], m2); end
      ST_PM: begin op_a = tmp_q[i_q][m2]; op_b = lane_s(phi_q[j_q], m2); end
      ST_PH: begin op_a = pm_q[i_q][m2];  op_b = lane_s(obs_q, m2); end
      ST_HP: begin op_a = pm_q[m2][i_q];  op_b = lane_s(obs_q, m2); end
      ST_S:  begin op_a = hp_q[m2];       op_b = lane_s(obs_q, m2); end
      ST_HX: begin op_a = xm_q[m2];       op_b = lane_s(obs_q, m2); end
      ST_XU: begin op_a = k_q[i_q];       op_b = eta_q; end
      ST_PU: begin op_a = k_q[i_q];       op_b = hp_q[j_q]; end
      default: ;
    endcase
  end

  // rounding, offset and saturation of a finished sum
  logic signed [63:0] acc_rnd, r64;
  logic signed [65:0] base66, fin_v;
  kf_sat_t            fin_s;

  assign sh16 = (state_q == ST_XU) || (state_q == ST_PU);
  assign neg  = (state_q == ST_PU);

  always_comb begin
    base66 = '0;
    unique case (state_q)
      ST_PM: if (i_q == j_q) base66 = 66'(noise_q[16*(32'(i_q) + 1) +: 16]) <<< 4;
      ST_S:  base66 = 66'(noise_q[15:0]) <<< 4;
      ST_XU: base66 = {{34{xm_q[i_q][31]}}, xm_q[i_q]};
      ST_PU: base66 = {{34{pm_q[i_q][j_q][31]}}, pm_q[i_q][j_q]};
      default: ;
    endcase
    acc_rnd = acc_q + (sh16 ? 64'sd32768 : 64'sd8192);
    r64     = sh16 ? (acc_rnd >>> 16) : (acc_rnd >>> 14);
    fin_v   = neg ? base66 - {{2{r64[63]}}, r64} : base66 + {{2{r64[63]}}, r64};
    fin_s   = sat32(fin_v);
  end

  // innovation
  logic signed [33:0] eta_diff;
  kf_sat_t            eta_s;
  assign eta_diff = {{2{y_q[31]}}, y_q} - {{2{hx_q[31]}}, hx_q};
  assign eta_s    = sat32({{32{eta_diff[33]}}, eta_diff});

  // divider step and operand preparation
  logic [32:0] rem_sh, rem_sub;
  logic        rem_ge;
  logic signed [47:0] gain_n;
  logic [47:0] gain_an;
  logic [31:0] gain_ad;
  logic signed [48:0] q_s;
  kf_sat_t            gain_s;

  assign rem_sh  = {drem_q, dnum_q[47]};
  assign rem_sub = rem_sh - {1'b0, dden_q};
  assign rem_ge  = (rem_sh >= {1'b0, dden_q});

  assign gain_n  = {ph_q[i_q], 16'h0000};
  assign gain_an = gain_n[47] ? 48'(-gain_n) : 48'(gain_n);
  assign gain_ad = s_q[31] ? 32'(-s_q) : 32'(s_q);
  assign q_s     = dneg_q ? -$signed({1'b0, dnum_q}) : $signed({1'b0, dnum_q});
  assign gain_s  = sat32({{17{q_s[48]}}, q_s});

  // control, configuration and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sub_q       <= SUB_ISSUE;
      i_q         <= '0;
      j_q         <= '0;
      m_q         <= '0;
      pvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
      phi_q[0]    <= PHI_0_RST;
      phi_q[1]    <= PHI_1_RST;
      phi_q[2]    <= PHI_2_RST;
      gam_q[0]    <= GAMMA_0_RST;
      gam_q[1]    <= GAMMA_1_RST;
      gam_q[2]    <= GAMMA_2_RST;
      obs_q       <= OBS_RST;
      noise_q     <= NOISE_RST;
      for (int a = 0; a < STATE_COUNT; a++) begin
        x_q[a] <= '0;
        for (int b = 0; b < STATE_COUNT; b++) begin
          p_q[a][b] <= (a == b) ? P_DIAG_RST : '0;
        end
      end
    end else begin
      state_q <= state_d;
      sub_q   <= sub_d;
      i_q     <= i_d;
      j_q     <= j_d;
      m_q     <= m_d;
      pvld_q  <= issue_mac;

      if (state_q == ST_DONE && !out_valid_q) begin
        out_valid_q <= 1'b1;
      end else if (state_q == ST_DONE && out_ready_i) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_PHI_0:   phi_q[0] <= cfg_data_i[47:0];
          CFG_PHI_1:   phi_q[1] <= cfg_data_i[47:0];
          CFG_PHI_2:   phi_q[2] <= cfg_data_i[47:0];
          CFG_GAMMA_0: gam_q[0] <= cfg_data_i[47:0];
          CFG_GAMMA_1: gam_q[1] <= cfg_data_i[47:0];
          CFG_GAMMA_2: gam_q[2] <= cfg_data_i[47:0];
          CFG_OBS:     obs_q    <= cfg_data_i[47:0];
          CFG_NOISE:   noise_q  <= cfg_data_i;
          default: ;
        endcase
      end

      if (fin && state_q == ST_XU) x_q[i_q] <= fin_s.val;
      if (fin && state_q == ST_PU) p_q[i_q][j_q] <= fin_s.val;
    end
  end

  // datapath scratch
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      raw_q <= in_data_i;
      ovf_q <= 1'b0;
      acc_q <= '0;
    end

    if (issue_mac) prod_q <= op_a * op_b;

    if (fin) begin
      acc_q <= '0;
    end else if (pvld_q) begin
      acc_q <= acc_q + prod_q;
    end

    // divider load and iteration, gains only
    if (is_div && sub_q == SUB_ISSUE) begin
      drem_q <= '0;
      dcnt_q <= '0;
      dnum_q <= gain_an + 48'(gain_ad >> 1);
      dden_q <= gain_ad;
      dneg_q <= gain_n[47] ^ s_q[31];
    end else if (is_div && sub_q == SUB_WAIT) begin
      drem_q <= rem_ge ? rem_sub[31:0] : rem_sh[31:0];
      dnum_q <= {dnum_q[46:0], rem_ge};
      dcnt_q <= dcnt_q + 6'd1;
    end

    if (fin) begin
      unique case (state_q)
        ST_CONV: begin
          if (i_q == 2'd0) y_q <= conv_val;
          else u_q[2'(i_q - 2'd1)] <= conv_val;
        end
        ST_GAIN: begin
          if (s_q == '0) begin
            k_q[i_q] <= '0;
            ovf_q    <= 1'b1;
          end else begin
            k_q[i_q] <= gain_s.val;
            if (gain_s.ov) ovf_q <= 1'b1;
          end
        end
        default: if (fin_s.ov) ovf_q <= 1'b1;
      endcase
      unique case (state_q)
        ST_XP: xm_q[i_q]        <= fin_s.val;
        ST_PT: tmp_q[i_q][j_q]  <= fin_s.val;
        ST_PM: pm_q[i_q][j_q]   <= fin_s.val;
        ST_PH: ph_q[i_q]        <= fin_s.val;
        ST_HP: hp_q[i_q]        <= fin_s.val;
        ST_S:  s_q              <= fin_s.val;
        ST_HX: hx_q             <= fin_s.val;
        default: ;
      endcase
    end

    if (state_q == ST_ETA) begin
      eta_q <= eta_s.val;
      if (eta_s.ov) ovf_q <= 1'b1;
    end

    if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
      out_q.estimate_0 <= x_q[0];
      out_q.estimate_1 <= x_q[1];
      out_q.estimate_2 <= x_q[2];
      out_q.overflow   <= ovf_q;
    end
  end

endmodule
